@@ hw/rtl/bcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bcsr_pkg
// Shared types and constants for the block sparse row matrix-vector core.
// ----------------------------------------------------------------------------
package bcsr_pkg;

  localparam int VEC_DEPTH     = 1024;
  localparam int VEC_AW        = $clog2(VEC_DEPTH);
  localparam int MAX_BLOCK_DIM = 3;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int CMD_W  = 2;
  localparam int DIM_W  = 2;
  localparam int VLEN_W = 11;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam int IN_FIELDS_W  = COL_W + 9 * DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ROW_W + 3 * DATA_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Product kept down to the rounding bit: bits 63..15 of the full product.
  localparam int PROD_W = 2 * DATA_W - FRAC_W + 1;
  // Accumulator plus three rounded products plus their rounding carries.
  localparam int SUM_W  = PROD_W - 1 + 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DIM     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'd1;

  localparam logic [DIM_W-1:0]  BLOCK_DIM_RESET     = 2'd3;
  localparam logic [DIM_W-1:0]  BLOCK_DIM_2X2       = 2'd2;
  localparam logic [VLEN_W-1:0] VECTOR_LENGTH_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BLOCK = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic row_end;
    logic col_ok;
  } ctl_t;

  typedef logic [2:0][2:0][DATA_W-1:0] blk_t;
  typedef logic [2:0][DATA_W-1:0]      xvec_t;
  typedef logic [2:0][2:0][PROD_W-1:0] prod_t;

endpackage

@@ hw/rtl/block_csr_matrix_vector_multiply_core.sv @@
// ----------------------------------------------------------------------------
// block_csr_matrix_vector_multiply_core
// Block sparse row matrix-vector multiply over 2x2 or 3x3 Q16.16 blocks.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid / tready    command, column, row end, block
// m_*       out        tvalid / tready    row index, result vector, error
// cfg_*     in         write enable       block_dim, vector_length
//
// One word is accepted per cycle while s_tready is high; a result is presented
// after the word closing its row is accepted and has passed the store read register,
// the product register and the row accumulator, whose feedback is a single add
// per cycle.
// Reset is synchronous and clears control and row state; the vector store
// is not cleared. A stalled result register holds back only words that end
// a row; bubbles in the pipeline are filled while it waits.
// ----------------------------------------------------------------------------
module block_csr_matrix_vector_multiply_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // column, blk_00, blk_01, blk_02, blk_10, blk_11, blk_12, blk_20, blk_21, blk_22
  input  logic [bcsr_pkg::IN_TDATA_W-1:0]   s_tdata,
  // cmd
  input  logic [bcsr_pkg::CMD_W-1:0]        s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // row_index, res0, res1, res2
  output logic [bcsr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // col_error
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [bcsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcsr_pkg::CFG_W-1:0]        cfg_data
);

  logic [bcsr_pkg::DIM_W-1:0]  block_dim;
  logic [bcsr_pkg::VLEN_W-1:0] vector_length;
  logic dim2;

  logic             accept;
  bcsr_pkg::ctl_t   in_ctl;
  bcsr_pkg::blk_t   in_blk;
  logic [bcsr_pkg::COL_W-1:0] in_col;
  logic             in_range;

  logic             v1;
  bcsr_pkg::ctl_t   ctl1;
  bcsr_pkg::blk_t   blk1;
  bcsr_pkg::xvec_t  xv1;
  logic             rdy2;

  logic             v2;
  logic             rdy3;
  bcsr_pkg::ctl_t   ctl2;
  bcsr_pkg::prod_t  prod2;

  logic [bcsr_pkg::ROW_W-1:0]  row_index;
  logic [bcsr_pkg::DATA_W-1:0] res0;
  logic [bcsr_pkg::DATA_W-1:0] res1;
  logic [bcsr_pkg::DATA_W-1:0] res2;

  assign dim2 = (block_dim == bcsr_pkg::BLOCK_DIM_2X2) || (bcsr_pkg::MAX_BLOCK_DIM < 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_dim     <= bcsr_pkg::BLOCK_DIM_RESET;
      vector_length <= bcsr_pkg::VECTOR_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcsr_pkg::CFG_BLOCK_DIM:     block_dim     <= cfg_data[bcsr_pkg::DIM_W-1:0];
        bcsr_pkg::CFG_VECTOR_LENGTH: vector_length <= cfg_data[bcsr_pkg::VLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !v1 || rdy2;
  assign accept   = s_tvalid && s_tready;
  assign in_col   = s_tdata[bcsr_pkg::COL_W-1:0];
  assign in_range = 32'(in_col) < bcsr_pkg::VEC_DEPTH;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        in_blk[r][c] = s_tdata[bcsr_pkg::COL_W + (r * 3 + c) * bcsr_pkg::DATA_W +:
                               bcsr_pkg::DATA_W];
      end
    end
    in_ctl.cmd     = bcsr_pkg::cmd_t'(s_tuser);
    in_ctl.row_end = s_tlast;
    in_ctl.col_ok  = in_range && (bcsr_pkg::VLEN_W'(in_col) < vector_length);
  end

  bcsr_xstore u_xstore (
    .clk     (clk),
    .wr_en   (accept && in_ctl.cmd == bcsr_pkg::CMD_LOAD && in_range),
    .wr_addr (bcsr_pkg::VEC_AW'(in_col)),
    .wr_data (in_blk[0]),
    .rd_en   (accept),
    .rd_addr (bcsr_pkg::VEC_AW'(in_col)),
    .rd_data (xv1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1 <= in_ctl;
      blk1 <= in_blk;
    end
  end

  bcsr_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (rdy2),
    .in_ctl    (ctl1),
    .blk       (blk1),
    .xv        (xv1),
    .out_valid (v2),
    .out_ready (rdy3),
    .out_ctl   (ctl2),
    .prod      (prod2)
  );

  bcsr_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .dim2      (dim2),
    .in_valid  (v2),
    .in_ready  (rdy3),
    .in_ctl    (ctl2),
    .prod      (prod2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .row_index (row_index),
    .res0      (res0),
    .res1      (res1),
    .res2      (res2),
    .col_error (m_tuser)
  );

  assign m_tdata = bcsr_pkg::OUT_TDATA_W'({res2, res1, res0, row_index});

endmodule

@@ hw/rtl/bcsr_xstore.sv @@
// ----------------------------------------------------------------------------
// bcsr_xstore
// Vector store: one write port and one registered read port, three components
// per entry.
// ----------------------------------------------------------------------------
module bcsr_xstore (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [bcsr_pkg::VEC_AW-1:0] wr_addr,
  input  bcsr_pkg::xvec_t           wr_data,
  input  logic                      rd_en,
  input  logic [bcsr_pkg::VEC_AW-1:0] rd_addr,
  output bcsr_pkg::xvec_t           rd_data
);

  bcsr_pkg::xvec_t mem [bcsr_pkg::VEC_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/bcsr_mult.sv @@
// ----------------------------------------------------------------------------
// bcsr_mult
// Product stage: nine parallel block-entry by vector-component multiplies,
// registered down to the rounding bit.
// ----------------------------------------------------------------------------
module bcsr_mult (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bcsr_pkg::ctl_t   in_ctl,
  input  bcsr_pkg::blk_t   blk,
  input  bcsr_pkg::xvec_t  xv,
  output logic             out_valid,
  input  logic             out_ready,
  output bcsr_pkg::ctl_t   out_ctl,
  output bcsr_pkg::prod_t  prod
);

  logic signed [2*bcsr_pkg::DATA_W-1:0] full [3][3];
  bcsr_pkg::prod_t prod_next;
  logic fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        full[r][c] = $signed(blk[r][c]) * $signed(xv[c]);
        prod_next[r][c] = full[r][c][2*bcsr_pkg::DATA_W-1:bcsr_pkg::FRAC_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ctl <= in_ctl;
      prod    <= prod_next;
    end
  end

endmodule

@@ hw/rtl/bcsr_accum.sv @@
// ----------------------------------------------------------------------------
// bcsr_accum
// Row accumulator: rounds and sums the products into the row vector with
// saturation, and holds the finished row in the result register.
// ----------------------------------------------------------------------------
module bcsr_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          dim2,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bcsr_pkg::ctl_t                in_ctl,
  input  bcsr_pkg::prod_t               prod,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bcsr_pkg::ROW_W-1:0]    row_index,
  output logic [bcsr_pkg::DATA_W-1:0]   res0,
  output logic [bcsr_pkg::DATA_W-1:0]   res1,
  output logic [bcsr_pkg::DATA_W-1:0]   res2,
  output logic                          col_error
);

  localparam int SW = bcsr_pkg::SUM_W;
  localparam int DW = bcsr_pkg::DATA_W;
  localparam int PW = bcsr_pkg::PROD_W;

  logic [2:0][DW-1:0] acc;
  logic [2:0][DW-1:0] acc_next;
  logic [2:0][DW-1:0] blk_acc;
  logic [SW-1:0]      sum [3];
  logic [bcsr_pkg::ROW_W-1:0] row_count;
  logic [bcsr_pkg::ROW_W-1:0] row_count_next;
  logic row_err;
  logic row_err_next;
  logic err_now;
  logic emit;
  logic fire;

  assign emit = (in_ctl.cmd == bcsr_pkg::CMD_EMPTY) ||
                ((in_ctl.cmd == bcsr_pkg::CMD_BLOCK) && in_ctl.row_end);
  assign in_ready = !in_valid || !emit || !out_valid || out_ready;
  assign fire = in_valid && in_ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'($signed(acc[r]));
      for (int c = 0; c < 3; c++) begin
        if (!(dim2 && (r == 2 || c == 2))) begin
          sum[r] = sum[r] + SW'($signed(prod[r][c][PW-1:1])) + SW'(prod[r][c][0]);
        end
      end
      if (sum[r][SW-1:DW-1] == '0 || sum[r][SW-1:DW-1] == '1) begin
        blk_acc[r] = sum[r][DW-1:0];
      end else begin
        blk_acc[r] = {sum[r][SW-1], {(DW-1){!sum[r][SW-1]}}};
      end
    end
  end

  always_comb begin
    acc_next       = acc;
    row_err_next   = row_err;
    row_count_next = row_count;
    err_now        = row_err;
    case (in_ctl.cmd)
      bcsr_pkg::CMD_LOAD: begin
        acc_next       = '0;
        row_err_next   = 1'b0;
        row_count_next = '0;
      end
      bcsr_pkg::CMD_BLOCK: begin
        if (in_ctl.col_ok) begin
          acc_next[0] = blk_acc[0];
          acc_next[1] = blk_acc[1];
          if (!dim2) begin
            acc_next[2] = blk_acc[2];
          end
        end else begin
          row_err_next = 1'b1;
          err_now      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      row_err   <= 1'b0;
      row_count <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || (fire && emit);
      if (fire) begin
        if (emit) begin
          acc       <= '0;
          row_err   <= 1'b0;
          row_count <= row_count + bcsr_pkg::ROW_W'(1);
        end else begin
          acc       <= acc_next;
          row_err   <= row_err_next;
          row_count <= row_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      row_index <= row_count;
      res0      <= acc_next[0];
      res1      <= acc_next[1];
      res2      <= dim2 ? '0 : acc_next[2];
      col_error <= err_now;
    end
  end

  a_load_restart: assert property (@(posedge clk) disable iff (rst)
    fire && in_ctl.cmd == bcsr_pkg::CMD_LOAD |=> row_count == '0 && !row_err && acc == '0)
    else $error("load did not restart the row state");

  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> out_valid && row_index == $past(row_count))
    else $error("row end did not present its result");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid && emit |-> !in_ready)
    else $error("row result taken while the result register was full");

  a_res2_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dim2 |-> res2 == '0)
    else $error("third component not zero for 2x2 blocks");

endmodule
